[rtl/core/smart_beacon_decision_assert.svh]
// ---------------------------------------------------------------------------
// smart_beacon_decision assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ---------------------------------------------------------------------------
`ifndef SMART_BEACON_DECISION_ASSERT_SVH
`define SMART_BEACON_DECISION_ASSERT_SVH

// same-cycle implication
`define SBD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/sbd_pkg.sv]
// ---------------------------------------------------------------------------
// sbd_pkg
// Types, codes and constants of the beacon decision block.
// ---------------------------------------------------------------------------
package sbd_pkg;

   localparam int ELAPSED_BITS = 17;
   localparam int MUL_STEPS    = 8;    // bits of the serial multiplier operand
   localparam int DIV_STEPS    = 24;   // quotient bits of the serial divider
   localparam int CNT_W        = $clog2(DIV_STEPS);
   localparam int PROD_W       = 24;
   localparam int TPROD_W      = 18;

   localparam logic [12:0] LOW_BATT_MV = 13'd3500;

   // command codes
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_EVAL = 2'd1;
   localparam logic [1:0] CMD_SENT = 2'd2;
   localparam logic [1:0] CMD_NOP  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_LOW_SPEED      = 3'd0;
   localparam logic [2:0] REG_HIGH_SPEED     = 3'd1;
   localparam logic [2:0] REG_SLOW_RATE      = 3'd2;
   localparam logic [2:0] REG_FAST_RATE      = 3'd3;
   localparam logic [2:0] REG_TURN_MIN_ANGLE = 3'd4;
   localparam logic [2:0] REG_TURN_SLOPE     = 3'd5;
   localparam logic [2:0] REG_TURN_MIN_TIME  = 3'd6;
   localparam logic [2:0] REG_BATTERY_CHECK  = 3'd7;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        fix_valid;
      logic [9:0]  speed_kmh;
      logic [8:0]  course_deg;
      logic [12:0] battery_mv;
   } req_type;

   typedef struct packed {
      logic        transmit_now;
      logic        turn_trigger;
      logic [15:0] interval_sec;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   function automatic logic [8:0] mod360(input logic [8:0] d);
      return (d >= 9'd360) ? d - 9'd360 : d;
   endfunction

   // smaller angle between two headings, 0..180
   function automatic logic [7:0] heading_change(input logic [8:0] a, input logic [8:0] b);
      logic [8:0] x;
      logic [8:0] y;
      logic [8:0] d;
      x = mod360(a);
      y = mod360(b);
      d = (x > y) ? x - y : y - x;
      return (d > 9'd180) ? 8'(9'd360 - d) : d[7:0];
   endfunction

endpackage

[rtl/core/smart_beacon_decision.sv]
// Tick, beacon-sent and no-op go from acceptance straight to the done state; evaluate
// runs the multiply, and then the divide as well when the speed falls between the two speeds.
// The multiply is an 8-step bit-serial one and the divide a 24-step restoring divider.
// Transactions do not overlap: the next is accepted the cycle after the result enters
// the output register, and the done state waits there while the output is stalled.
// Reset (synchronous, active high): default registers, elapsed, heading, output valid cleared.
// ---------------------------------------------------------------------------
// smart_beacon_decision
// Position beacon scheduler: elapsed time, speed-based interval, corner pegging.
// ---------------------------------------------------------------------------
module smart_beacon_decision (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  sbd_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sbd_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [2:0]      csr_index,
   input  logic [15:0]     csr_wdata
);
   import sbd_pkg::*;

   // configuration
   logic [7:0]  low_speed_ff;
   logic [7:0]  high_speed_ff;
   logic [15:0] slow_rate_ff;
   logic [15:0] fast_rate_ff;
   logic [8:0]  turn_min_angle_ff;
   logic [15:0] turn_slope_ff;
   logic [15:0] turn_min_time_ff;
   logic        battery_check_ff;

   // block state
   logic [ELAPSED_BITS-1:0] elapsed_ff;
   logic [8:0]              heading_ff;

   // sequencer
   state_type  state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // datapath
   req_type            item_ff, item_in;
   logic               slow_ff, slow_in;
   logic               fast_ff, fast_in;
   logic [7:0]         diff_sr_ff, diff_sr_in;
   logic [7:0]         hs_sr_ff, hs_sr_in;
   logic [TPROD_W-1:0] tprod_ff, tprod_in;
   logic [PROD_W-1:0]  rprod_ff, rprod_in;
   logic [9:0]         rem_ff, rem_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic       req_take;
   logic       rsp_free;
   logic       rsp_load;
   logic       csr_write;
   logic [9:0] spd_m;
   logic [8:0] crs_m;
   logic [7:0] change;
   logic [10:0] trial;
   logic        trial_ge;
   logic [15:0] quot_sat;
   logic [15:0] base_rate;
   logic [15:0] final_rate;
   logic        turn_hit;
   logic        low_batt;
   rsp_type     result;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == ST_DONE) && rsp_free;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // invalid fix reads as zero speed and heading
   assign spd_m  = req_data.fix_valid ? req_data.speed_kmh : 10'd0;
   assign crs_m  = req_data.fix_valid ? req_data.course_deg : 9'd0;
   assign change = heading_change(heading_ff, crs_m);

   // restoring divider step: quotient shifts in at the bottom of rprod
   assign trial    = {rem_ff, rprod_ff[PROD_W-1]};
   assign trial_ge = (trial >= {1'b0, item_ff.speed_kmh});

   // decision
   assign quot_sat  = (|rprod_ff[PROD_W-1:16]) ? 16'hFFFF : rprod_ff[15:0];
   assign base_rate = slow_ff ? slow_rate_ff : (fast_ff ? fast_rate_ff : quot_sat);
   // (change-angle)*speed > slope is the exact form of the turn threshold
   assign turn_hit  = !slow_ff && (tprod_ff > TPROD_W'(turn_slope_ff)) &&
                      (elapsed_ff > ELAPSED_BITS'(turn_min_time_ff));
   assign low_batt  = battery_check_ff && (item_ff.battery_mv < LOW_BATT_MV);
   assign final_rate = (!turn_hit && low_batt) ? slow_rate_ff : base_rate;

   always_comb begin
      result = '0;
      if (item_ff.cmd == CMD_EVAL) begin
         result.turn_trigger = turn_hit;
         result.transmit_now = turn_hit || (elapsed_ff > ELAPSED_BITS'(final_rate));
         result.interval_sec = final_rate;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      item_in    = item_ff;
      slow_in    = slow_ff;
      fast_in    = fast_ff;
      diff_sr_in = diff_sr_ff;
      hs_sr_in   = hs_sr_ff;
      tprod_in   = tprod_ff;
      rprod_in   = rprod_ff;
      rem_in     = rem_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               item_in            = req_data;
               item_in.speed_kmh  = spd_m;
               item_in.course_deg = crs_m;
               slow_in    = (spd_m == 10'd0) || (spd_m < {2'b00, low_speed_ff});
               fast_in    = (spd_m > {2'b00, high_speed_ff});
               diff_sr_in = ({1'b0, change} > turn_min_angle_ff) ?
                            8'({1'b0, change} - turn_min_angle_ff) : 8'd0;
               hs_sr_in   = high_speed_ff;
               tprod_in   = '0;
               rprod_in   = '0;
               cnt_in     = '0;
               state_in   = (req_data.cmd == CMD_EVAL) ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            tprod_in   = {tprod_ff[TPROD_W-2:0], 1'b0} +
                         (diff_sr_ff[7] ? TPROD_W'(item_ff.speed_kmh) : '0);
            rprod_in   = {rprod_ff[PROD_W-2:0], 1'b0} +
                         (hs_sr_ff[7] ? PROD_W'(fast_rate_ff) : '0);
            diff_sr_in = {diff_sr_ff[6:0], 1'b0};
            hs_sr_in   = {hs_sr_ff[6:0], 1'b0};
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = (slow_ff || fast_ff) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in   = trial_ge ? 10'(trial - {1'b0, item_ff.speed_kmh}) : trial[9:0];
            rprod_in = {rprod_ff[PROD_W-2:0], trial_ge};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         cnt_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
         elapsed_ff        <= '0;
         heading_ff        <= '0;
         low_speed_ff      <= 8'd5;
         high_speed_ff     <= 8'd90;
         slow_rate_ff      <= 16'd1800;
         fast_rate_ff      <= 16'd60;
         turn_min_angle_ff <= 9'd28;
         turn_slope_ff     <= 16'd255;
         turn_min_time_ff  <= 16'd15;
         battery_check_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take && (req_data.cmd == CMD_TICK)) begin
            if (elapsed_ff != '1) begin
               elapsed_ff <= elapsed_ff + 1'b1;
            end
         end
         if (req_take && (req_data.cmd == CMD_SENT)) begin
            elapsed_ff <= '0;
            heading_ff <= crs_m;
         end
         if (csr_write) begin
            unique case (csr_index)
               REG_LOW_SPEED:      low_speed_ff      <= csr_wdata[7:0];
               REG_HIGH_SPEED:     high_speed_ff     <= csr_wdata[7:0];
               REG_SLOW_RATE:      slow_rate_ff      <= csr_wdata;
               REG_FAST_RATE:      fast_rate_ff      <= csr_wdata;
               REG_TURN_MIN_ANGLE: turn_min_angle_ff <= csr_wdata[8:0];
               REG_TURN_SLOPE:     turn_slope_ff     <= csr_wdata;
               REG_TURN_MIN_TIME:  turn_min_time_ff  <= csr_wdata;
               REG_BATTERY_CHECK:  battery_check_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      slow_ff     <= slow_in;
      fast_ff     <= fast_in;
      diff_sr_ff  <= diff_sr_in;
      hs_sr_ff    <= hs_sr_in;
      tprod_ff    <= tprod_in;
      rprod_ff    <= rprod_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

`include "smart_beacon_decision_assert.svh"

   `SBD_ASSERT_NEXT(a_busy_after_accept, req_take, req_stall, "accepted transaction did not make the block busy")
   `SBD_ASSERT_NEXT(a_done_loads_output, rsp_load, (state_ff == ST_IDLE) && rsp_valid_ff, "finished result not loaded into output register")
   `SBD_ASSERT_IMPL(a_turn_implies_tx, rsp_valid_ff && rsp_data_ff.turn_trigger, rsp_data_ff.transmit_now, "turn result without transmit request")

endmodule

[verif/tb_smart_beacon_decision.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_smart_beacon_decision
// Drives tick, evaluate, beacon-sent and no-op transactions into the beacon
// scheduler under several register settings, predicts every decision in the
// bench and checks each result field in order. Both sides idle in bursts.
// ---------------------------------------------------------------------------
module tb_smart_beacon_decision;
   import sbd_pkg::*;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [2:0] csr_index;
   logic [15:0] csr_wdata;

   smart_beacon_decision DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bench copy of the register file and scheduler state
   logic [7:0]              cfg_low_speed;
   logic [7:0]              cfg_high_speed;
   logic [15:0]             cfg_slow_rate;
   logic [15:0]             cfg_fast_rate;
   logic [8:0]              cfg_turn_min_angle;
   logic [15:0]             cfg_turn_slope;
   logic [15:0]             cfg_turn_min_time;
   logic                    cfg_battery_check;
   logic [ELAPSED_BITS-1:0] elapsed_secs;
   logic [8:0]              heading_ref;

   req_type cmd_q[$];
   rsp_type decision_q[$];
   int      queued_n;
   int      accepted_n;
   int      fail_n;
   int      gap_left;
   int      stall_left;
   bit      idle_on;
   logic    req_taken;

   function automatic rsp_type beacon_decide(input req_type r);
      longint unsigned spd;
      longint unsigned crs;
      longint unsigned rate;
      longint unsigned x;
      longint unsigned y;
      longint unsigned d;
      logic            turn;
      rsp_type         o;
      o    = '0;
      turn = 1'b0;
      spd  = r.fix_valid ? r.speed_kmh : 0;
      crs  = r.fix_valid ? r.course_deg : 0;
      case (r.cmd)
         CMD_TICK: begin
            if (elapsed_secs != '1) elapsed_secs = elapsed_secs + 1'b1;
         end
         CMD_SENT: begin
            elapsed_secs = '0;
            heading_ref  = crs[8:0];
         end
         CMD_EVAL: begin
            // zero speed counts as stopped even with low_speed at its floor
            if (spd == 0 || spd < cfg_low_speed) begin
               rate = cfg_slow_rate;
            end else begin
               x = (heading_ref >= 360) ? heading_ref - 360 : heading_ref;
               y = (crs >= 360) ? crs - 360 : crs;
               d = (x > y) ? x - y : y - x;
               if (d > 180) d = 360 - d;
               if (spd > cfg_high_speed) begin
                  rate = cfg_fast_rate;
               end else begin
                  rate = (longint'(cfg_fast_rate) * cfg_high_speed) / spd;
                  if (rate > 65535) rate = 65535;
               end
               turn = (d * spd > longint'(cfg_turn_min_angle) * spd + cfg_turn_slope)
                      && (elapsed_secs > cfg_turn_min_time);
            end
            // the low-battery override does not apply to a turn beacon
            if (!turn && cfg_battery_check && r.battery_mv < LOW_BATT_MV)
               rate = cfg_slow_rate;
            o.transmit_now = turn || (elapsed_secs > rate);
            o.turn_trigger = turn;
            o.interval_sec = rate[15:0];
         end
         default: ;
      endcase
      return o;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left  = gap_left - 1;
            req_valid <= 1'b0;
         end else if (cmd_q.size() > 0) begin
            req_data  <= cmd_q.pop_front();
            req_valid <= 1'b1;
            if (idle_on && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 18);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: check results, predict accepted transactions
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (decision_q.size() == 0) begin
               $error("result with no decision pending");
               fail_n++;
            end else begin
               want = decision_q.pop_front();
               if (rsp_data.transmit_now !== want.transmit_now) begin
                  $error("transmit_now: expected %0d, got %0d",
                         want.transmit_now, rsp_data.transmit_now);
                  fail_n++;
               end
               if (rsp_data.turn_trigger !== want.turn_trigger) begin
                  $error("turn_trigger: expected %0d, got %0d",
                         want.turn_trigger, rsp_data.turn_trigger);
                  fail_n++;
               end
               if (rsp_data.interval_sec !== want.interval_sec) begin
                  $error("interval_sec: expected %0d, got %0d",
                         want.interval_sec, rsp_data.interval_sec);
                  fail_n++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            decision_q.push_back(beacon_decide(req_data));
            accepted_n++;
         end
      end
   end

   function automatic req_type mk(input logic [1:0] c, input logic v, input logic [9:0] s,
                                  input logic [8:0] crs, input logic [12:0] b);
      req_type r;
      r.cmd        = c;
      r.fix_valid  = v;
      r.speed_kmh  = s;
      r.course_deg = crs;
      r.battery_mv = b;
      return r;
   endfunction

   function automatic logic [9:0] pick_speed();
      case ($urandom_range(0, 7))
         0:       return 10'd0;
         1:       return 10'($urandom_range(0, 1023));
         2:       return 10'(cfg_low_speed - 1 + $urandom_range(0, 2));
         3:       return 10'(cfg_high_speed - 1 + $urandom_range(0, 2));
         default: return 10'($urandom_range(1, cfg_high_speed + 10));
      endcase
   endfunction

   function automatic logic [8:0] pick_course();
      if ($urandom_range(0, 7) == 0) return 9'($urandom_range(360, 511));
      return 9'($urandom_range(0, 359));
   endfunction

   function automatic logic [12:0] pick_batt();
      if ($urandom_range(0, 3) == 0) return 13'($urandom_range(3495, 3505));
      return 13'($urandom_range(0, 8191));
   endfunction

   function automatic logic pick_valid();
      return $urandom_range(0, 9) != 0;
   endfunction

   task automatic add_item(input req_type r);
      cmd_q.push_back(r);
      queued_n++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_LOW_SPEED:      cfg_low_speed      = val[7:0];
         REG_HIGH_SPEED:     cfg_high_speed     = val[7:0];
         REG_SLOW_RATE:      cfg_slow_rate      = val;
         REG_FAST_RATE:      cfg_fast_rate      = val;
         REG_TURN_MIN_ANGLE: cfg_turn_min_angle = val[8:0];
         REG_TURN_SLOPE:     cfg_turn_slope     = val;
         REG_TURN_MIN_TIME:  cfg_turn_min_time  = val;
         REG_BATTERY_CHECK:  cfg_battery_check  = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_all(input int ls, input int hs, input int sr, input int fr,
                              input int ang, input int slope, input int tmin, input int bchk);
      csr_write(REG_LOW_SPEED, 16'(ls));
      csr_write(REG_HIGH_SPEED, 16'(hs));
      csr_write(REG_SLOW_RATE, 16'(sr));
      csr_write(REG_FAST_RATE, 16'(fr));
      csr_write(REG_TURN_MIN_ANGLE, 16'(ang));
      csr_write(REG_TURN_SLOPE, 16'(slope));
      csr_write(REG_TURN_MIN_TIME, 16'(tmin));
      csr_write(REG_BATTERY_CHECK, 16'(bchk));
   endtask

   task automatic random_program(input bit no_turn_time);
      int ls;
      int hs;
      ls = $urandom_range(1, 60);
      hs = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(ls, 255);
      program_all(ls, hs,
                  ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4000) : $urandom_range(1, 65535),
                  ($urandom_range(0, 1) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 65535),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 359) : $urandom_range(0, 60),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2000),
                  no_turn_time ? 65535 : $urandom_range(0, 20),
                  $urandom_range(0, 1));
   endtask

   // mostly groups of one beacon-sent, a run of ticks, then a few evaluations; some noise
   task automatic queue_random(input int n);
      int left;
      int k;
      int e;
      left = n;
      while (left > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            add_item(mk(2'($urandom), 1'($urandom), 10'($urandom), 9'($urandom), 13'($urandom)));
            left--;
         end else begin
            k = $urandom_range(0, 24);
            e = $urandom_range(1, 6);
            add_item(mk(CMD_SENT, pick_valid(), pick_speed(), pick_course(), pick_batt()));
            repeat (k)
               add_item(mk(CMD_TICK, 1'($urandom), 10'($urandom), 9'($urandom), 13'($urandom)));
            repeat (e) add_item(mk(CMD_EVAL, pick_valid(), pick_speed(), pick_course(), pick_batt()));
            left = left - 1 - k - e;
         end
      end
   endtask

   task automatic wait_drained();
      while (accepted_n != queued_n || decision_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_stall  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_taken  = 1'b0;
      queued_n   = 0;
      accepted_n = 0;
      fail_n     = 0;
      gap_left   = 0;
      stall_left = 0;
      idle_on    = 1'b1;
      cfg_low_speed      = 8'd5;
      cfg_high_speed     = 8'd90;
      cfg_slow_rate      = 16'd1800;
      cfg_fast_rate      = 16'd60;
      cfg_turn_min_angle = 9'd28;
      cfg_turn_slope     = 16'd255;
      cfg_turn_min_time  = 16'd15;
      cfg_battery_check  = 1'b0;
      elapsed_secs       = '0;
      heading_ref        = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset defaults except turn time and battery check
      csr_write(REG_TURN_MIN_TIME, 16'd0);
      csr_write(REG_BATTERY_CHECK, 16'd1);
      add_item(mk(CMD_EVAL, 1'b1, 10'd0, 9'd0, 13'd8191));
      add_item(mk(CMD_TICK, 1'b0, 10'd0, 9'd0, 13'd0));
      add_item(mk(CMD_SENT, 1'b1, 10'd0, 9'd350, 13'd4000));
      add_item(mk(CMD_TICK, 1'b1, 10'd1023, 9'd511, 13'd8191));
      add_item(mk(CMD_EVAL, 1'b1, 10'd50, 9'd10, 13'd4000));   // wraps: change of 20
      add_item(mk(CMD_EVAL, 1'b1, 10'd50, 9'd80, 13'd4000));
      add_item(mk(CMD_EVAL, 1'b1, 10'd50, 9'd400, 13'd4000));  // course past 359
      add_item(mk(CMD_EVAL, 1'b1, 10'd4, 9'd180, 13'd3499));
      add_item(mk(CMD_EVAL, 1'b1, 10'd50, 9'd350, 13'd3499));
      add_item(mk(CMD_EVAL, 1'b1, 10'd50, 9'd350, 13'd3500));
      add_item(mk(CMD_EVAL, 1'b1, 10'd0, 9'd180, 13'd0));
      add_item(mk(CMD_EVAL, 1'b0, 10'd1023, 9'd511, 13'd0));
      add_item(mk(CMD_EVAL, 1'b1, 10'd91, 9'd170, 13'd0));
      add_item(mk(CMD_EVAL, 1'b1, 10'd1023, 9'd359, 13'd8191));
      add_item(mk(CMD_EVAL, 1'b1, 10'd1, 9'd170, 13'd8191));
      add_item(mk(CMD_EVAL, 1'b1, 10'd5, 9'd170, 13'd8191));
      add_item(mk(CMD_EVAL, 1'b1, 10'd90, 9'd170, 13'd8191));
      add_item(mk(CMD_NOP, 1'b1, 10'd1023, 9'd511, 13'd8191));
      add_item(mk(CMD_SENT, 1'b0, 10'd700, 9'd300, 13'd0));
      add_item(mk(CMD_TICK, 1'b0, 10'd0, 9'd0, 13'd0));
      add_item(mk(CMD_EVAL, 1'b1, 10'd60, 9'd359, 13'd5000));
      add_item(mk(CMD_EVAL, 1'b1, 10'd60, 9'd180, 13'd5000));
      wait_drained();

      // extremes of the register ranges
      program_all(1, 1, 1, 1, 0, 0, 0, 1);
      queue_random(200);
      wait_drained();
      idle_on = 1'b0;
      program_all(255, 255, 65535, 65535, 359, 65535, 65535, 0);
      queue_random(200);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         idle_on = (p != 3);
         random_program(1'b0);
         queue_random(220);
         wait_drained();
      end

      // no idling from here on: a tick run with evaluations mixed in
      idle_on = 1'b0;
      random_program(1'b1);
      add_item(mk(CMD_SENT, 1'b1, 10'd30, 9'd0, 13'd4000));
      for (int t = 1; t <= 40; t++) begin
         add_item(mk(CMD_TICK, 1'($urandom), 10'($urandom), 9'($urandom), 13'($urandom)));
         if (t % 8 == 0)
            add_item(mk(CMD_EVAL, 1'b1, pick_speed(), pick_course(), pick_batt()));
      end
      add_item(mk(CMD_EVAL, 1'b1, 10'd1023, 9'd90, 13'd8191));
      wait_drained();
      random_program(1'b0);
      queue_random(150);
      wait_drained();

      repeat (40) @(posedge clock);
      if (fail_n == 0 && decision_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
